>>> rtl/lfu_pkg.sv
// shared types and constants for the lfu cache table
// no dependencies
package lfu_pkg;

  localparam int unsigned LFU_ENTRIES    = 16;
  localparam int unsigned LFU_KEY_BITS   = 32;
  localparam int unsigned LFU_VALUE_BITS = 32;
  localparam int unsigned LFU_COUNT_BITS = 16;

  localparam int unsigned LFU_IDX_MAXW   = 8;
  localparam int unsigned LFU_CNT_MAXW   = 32;
  localparam int unsigned LFU_FIELD_BITS = 32;
  localparam int unsigned LFU_CAP_BITS   = 5;
  localparam int unsigned LFU_CAP_RESET  = 16;

  localparam logic LFU_KIND_GET = 1'b0;
  localparam logic LFU_KIND_PUT = 1'b1;

  localparam logic LFU_REG_CAPACITY = 1'b0;

  typedef logic [LFU_IDX_MAXW-1:0] lfu_idx_t;
  typedef logic [LFU_CNT_MAXW-1:0] lfu_cnt_t;

  // partial scan result handed from cell to cell
  typedef struct packed {
    logic     found;
    lfu_idx_t found_idx;
    lfu_idx_t found_age;
    logic     free;
    lfu_idx_t free_idx;
    logic     vic;
    lfu_idx_t vic_idx;
    lfu_cnt_t vic_cnt;
    lfu_idx_t vic_age;
  } lfu_tok_t;

  // update broadcast to all cells
  typedef struct packed {
    logic     en;
    logic     bump;
    logic     wr_val;
    lfu_idx_t bump_idx;
    lfu_idx_t bump_age;
    logic     evict;
    lfu_idx_t vic_idx;
    lfu_idx_t vic_age;
    logic     insert;
    lfu_idx_t slot_idx;
  } lfu_cmd_t;

endpackage

>>> rtl/lfu_if.sv
// request and response channel interfaces
// depends on lfu_pkg
interface lfu_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic [lfu_pkg::LFU_FIELD_BITS-1:0]   lookup_key;
  logic [lfu_pkg::LFU_FIELD_BITS-1:0]   write_value;
  modport source (output valid, kind, lookup_key, write_value, input ready);
  modport sink   (input valid, kind, lookup_key, write_value, output ready);
endinterface

interface lfu_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 hit;
  logic [lfu_pkg::LFU_FIELD_BITS-1:0]   read_value;
  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

>>> rtl/lfu_cell.sv
// one table entry: key, value, use count, age rank, and one scan stage
// depends on lfu_pkg
module lfu_cell #(
  parameter int unsigned INDEX      = 0,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] wr_value_i,
  input  lfu_pkg::lfu_tok_t     tok_i,
  input  logic [VALUE_BITS-1:0] val_i,
  output lfu_pkg::lfu_tok_t     tok_o,
  output logic [VALUE_BITS-1:0] val_o,
  input  lfu_pkg::lfu_cmd_t     cmd_i,
  output logic                  match_o
);
  import lfu_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam lfu_idx_t MY_IDX = LFU_IDX_MAXW'(INDEX);

  logic                  valid_q, valid_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0]      age_q, age_d;
  lfu_tok_t              tok_q, tok_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  is_vic;

  assign match_o = valid_q && (key_q == key_i);

  always_comb begin
    tok_d = tok_i;
    val_d = val_i;
    if (valid_q) begin
      if (!tok_i.found && key_q == key_i) begin
        tok_d.found     = 1'b1;
        tok_d.found_idx = MY_IDX;
        tok_d.found_age = LFU_IDX_MAXW'(age_q);
        val_d           = value_q;
      end
      if (!tok_i.vic || cnt_q < tok_i.vic_cnt[COUNT_BITS-1:0] ||
          (cnt_q == tok_i.vic_cnt[COUNT_BITS-1:0] &&
           age_q > tok_i.vic_age[IDX_W-1:0])) begin
        tok_d.vic     = 1'b1;
        tok_d.vic_idx = MY_IDX;
        tok_d.vic_cnt = LFU_CNT_MAXW'(cnt_q);
        tok_d.vic_age = LFU_IDX_MAXW'(age_q);
      end
    end else if (!tok_i.free) begin
      tok_d.free     = 1'b1;
      tok_d.free_idx = MY_IDX;
    end
  end

  assign tok_o = tok_q;
  assign val_o = val_q;
  assign is_vic = cmd_i.evict && (cmd_i.vic_idx == MY_IDX);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    cnt_d   = cnt_q;
    age_d   = age_q;
    if (cmd_i.en) begin
      if (cmd_i.bump) begin
        if (cmd_i.bump_idx == MY_IDX) begin
          if (cnt_q != CNT_MAX) cnt_d = cnt_q + 1'b1;
          age_d = '0;
          if (cmd_i.wr_val) value_d = wr_value_i;
        end else if (valid_q && age_q < cmd_i.bump_age[IDX_W-1:0]) begin
          age_d = age_q + 1'b1;
        end
      end else begin
        if (valid_q && !is_vic) begin
          age_d = age_q - IDX_W'(cmd_i.evict && age_q > cmd_i.vic_age[IDX_W-1:0])
                  + IDX_W'(cmd_i.insert);
        end
        if (is_vic) valid_d = 1'b0;
        if (cmd_i.insert && cmd_i.slot_idx == MY_IDX) begin
          valid_d = 1'b1;
          key_d   = key_i;
          value_d = wr_value_i;
          cnt_d   = COUNT_BITS'(1);
          age_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
    cnt_q   <= cnt_d;
    age_q   <= age_d;
    val_q   <= val_d;
  end

endmodule

>>> rtl/lfu_cache_table.sv
// lfu cache table top level: request latch, scan sequencer, cell chain, apb register
// depends on lfu_pkg, lfu_if, lfu_cell
//
// channel  dir  transaction
// req_i    in   kind, lookup_key, write_value
// rsp_o    out  hit, read_value
// apb      in   capacity register write/read at byte address 0
//
// a request passes through accept, a scan in which the token walks the
// cell chain, and a commit step that updates all cells
// the commit waits while the previous response is not yet taken
// reset clears entry valid bits and occupancy, capacity resets to 16
module lfu_cache_table #(
  parameter int unsigned ENTRIES    = lfu_pkg::LFU_ENTRIES,
  parameter int unsigned KEY_BITS   = lfu_pkg::LFU_KEY_BITS,
  parameter int unsigned VALUE_BITS = lfu_pkg::LFU_VALUE_BITS,
  parameter int unsigned COUNT_BITS = lfu_pkg::LFU_COUNT_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lfu_req_if.sink             req_i,
  lfu_rsp_if.source           rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import lfu_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [IDX_W-1:0]        cnt_q, cnt_d;
  logic [LFU_CAP_BITS-1:0] cap_q;
  logic [OCC_W-1:0]        occ_q, occ_d;
  logic                    kind_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [VALUE_BITS-1:0]   wval_q;
  logic                    rsp_valid_q;
  logic                    rsp_hit_q;
  logic [LFU_FIELD_BITS-1:0] rsp_val_q;

  lfu_tok_t              tok [ENTRIES+1];
  logic [VALUE_BITS-1:0] tval [ENTRIES+1];
  logic [ENTRIES-1:0]    match;
  lfu_cmd_t              cmd;
  lfu_tok_t              ft;
  logic [OCC_W-1:0]      cap;
  logic                  commit;
  logic                  put_miss;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == LFU_REG_CAPACITY) ? 32'(cap_q) : '0;

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.hit   = rsp_hit_q;
  assign rsp_o.read_value = rsp_val_q;

  assign tok[0]  = '0;
  assign tval[0] = '0;
  assign ft      = tok[ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell #(
      .INDEX(g), .IDX_W(IDX_W), .KEY_BITS(KEY_BITS),
      .VALUE_BITS(VALUE_BITS), .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk_i, .rst_ni,
      .key_i(key_q), .wr_value_i(wval_q),
      .tok_i(tok[g]), .val_i(tval[g]),
      .tok_o(tok[g+1]), .val_o(tval[g+1]),
      .cmd_i(cmd), .match_o(match[g])
    );
  end

  assign cap = (32'(cap_q) > ENTRIES) ? OCC_W'(ENTRIES) : OCC_W'(cap_q);
  assign commit = (state_q == ST_COMMIT) && (!rsp_valid_q || rsp_o.ready);
  assign put_miss = (kind_q == LFU_KIND_PUT) && !ft.found && (cap != '0);

  always_comb begin
    cmd = '0;
    cmd.en       = commit;
    cmd.bump     = ft.found && (kind_q == LFU_KIND_GET || cap != '0);
    cmd.wr_val   = (kind_q == LFU_KIND_PUT);
    cmd.bump_idx = ft.found_idx;
    cmd.bump_age = ft.found_age;
    cmd.vic_idx  = ft.vic_idx;
    cmd.vic_age  = ft.vic_age;
    if (put_miss) begin
      cmd.evict  = (occ_q >= cap || !ft.free) && ft.vic;
      cmd.insert = cmd.evict || ft.free;
      if (cmd.evict && !(ft.free && ft.free_idx < ft.vic_idx)) cmd.slot_idx = ft.vic_idx;
      else cmd.slot_idx = ft.free_idx;
    end
    occ_d = occ_q;
    if (commit) occ_d = occ_q - OCC_W'(cmd.evict) + OCC_W'(cmd.insert);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == IDX_W'(ENTRIES - 1)) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      occ_q       <= '0;
      cap_q       <= LFU_CAP_BITS'(LFU_CAP_RESET);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      occ_q   <= occ_d;
      if (psel && penable && pwrite && paddr[2] == LFU_REG_CAPACITY) begin
        cap_q <= pwdata[LFU_CAP_BITS-1:0];
      end
      if (commit) rsp_valid_q <= 1'b1;
      else if (rsp_o.ready) rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      kind_q <= req_i.kind;
      key_q  <= KEY_BITS'(req_i.lookup_key);
      wval_q <= VALUE_BITS'(req_i.write_value);
    end
    if (commit) begin
      rsp_hit_q <= ft.found;
      rsp_val_q <= (ft.found && kind_q == LFU_KIND_GET) ?
                   LFU_FIELD_BITS'(tval[ENTRIES]) : '0;
    end
  end

`ifndef SYNTH
  a_key_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(match) <= 1) else $error("duplicate key in table");
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) <= ENTRIES) else $error("occupancy out of range");
  a_commit_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> rsp_valid_q) else $error("commit without response");
  a_scan_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !req_i.ready) else $error("ready during scan");
`endif

endmodule
